### rtl/core/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg: shared types and constants for the piecewise linear table core
// Operation codes, sequencer states, stream field positions and the fixed
// arithmetic limits of the signed Q16.16 datapath.
// ----------------------------------------------------------------------------
package pwl_pkg;

   // stream payload widths, padded to whole bytes
   localparam int REQ_W = 104;
   localparam int RSP_W = 40;

   // request field positions inside req_tdata
   localparam int OP_LSB          = 0;
   localparam int POINT_TIME_LSB  = 2;
   localparam int POINT_VALUE_LSB = 34;
   localparam int QUERY_TIME_LSB  = 66;

   // response field positions inside rsp_tdata
   localparam int INTERP_VALUE_LSB = 0;
   localparam int TABLE_EMPTY_BIT  = 32;
   localparam int SATURATED_BIT    = 33;

   // multiply / divide unit
   localparam int MAG_W     = 33;
   localparam int PROD_W    = 65;
   localparam int STEP_W    = 7;
   localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(MAG_W);
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(PROD_W);

   // Q16.16 constants
   localparam logic signed [32:0] SPAN_ONE   = 33'sd65536;
   localparam logic [PROD_W-1:0]  SAT_LIMIT  = PROD_W'(1) << 33;
   localparam logic signed [35:0] SUM_MAX    = 36'sd2147483647;
   localparam logic signed [35:0] SUM_MIN    = -36'sd2147483648;
   localparam logic signed [31:0] Q_MAX      = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_EXT_LO,
      S_LAST,
      S_EXT_HI,
      S_SEARCH,
      S_PROBE,
      S_PAIR0,
      S_PAIR1,
      S_CALC,
      S_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      M_IDLE,
      M_MUL,
      M_DIV
   } mdu_phase_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag_a;
      logic [MAG_W-1:0] mag_b;
      logic [MAG_W-1:0] mag_d;
      logic             start;
   } mdu_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } mdu_rsp_type;

endpackage

### rtl/core/pwl_ram.sv
// ----------------------------------------------------------------------------
// pwl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pwl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pwl_mdu.sv
// ----------------------------------------------------------------------------
// pwl_mdu: iterative unsigned multiply-then-divide unit
// Forms (a * b) / d by shift-add over 33 steps and restoring division
// over 65 steps, sharing one product/quotient register.
// ----------------------------------------------------------------------------
module pwl_mdu (
   input  logic                 clock,
   input  logic                 reset,
   input  pwl_pkg::mdu_req_type mdu_req,
   output pwl_pkg::mdu_rsp_type mdu_rsp
);
   import pwl_pkg::*;

   mdu_phase_type     phase_ff, phase_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  a_ff, a_in;
   logic [MAG_W-1:0]  b_ff, b_in;
   logic [MAG_W-1:0]  d_ff, d_in;

   logic [PROD_W-1:0] mul_acc;
   logic [MAG_W+1:0]  trial;
   logic              take;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= M_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
   end

   always_comb begin
      // shift-add: the product grows from the top bit of b down
      mul_acc = {acc_ff[PROD_W-2:0], 1'b0}
              + (b_ff[MAG_W-1] ? PROD_W'(a_ff) : '0);
      // restoring divide: bring down the next dividend bit, try subtract
      trial = {1'b0, rem_ff, acc_ff[PROD_W-1]} - {2'b00, d_ff};
      take  = ~trial[MAG_W+1];

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;

      unique case (phase_ff)
         M_IDLE: begin
            if (mdu_req.start) begin
               a_in     = mdu_req.mag_a;
               b_in     = mdu_req.mag_b;
               d_in     = mdu_req.mag_d;
               acc_in   = '0;
               rem_in   = '0;
               cnt_in   = MUL_STEPS - STEP_W'(1);
               phase_in = M_MUL;
            end
         end
         M_MUL: begin
            acc_in = mul_acc;
            b_in   = {b_ff[MAG_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_in   = DIV_STEPS - STEP_W'(1);
               phase_in = M_DIV;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         M_DIV: begin
            rem_in = take ? trial[MAG_W-1:0] : {rem_ff[MAG_W-2:0], acc_ff[PROD_W-1]};
            acc_in = {acc_ff[PROD_W-2:0], take};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               phase_in = M_IDLE;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         default: begin
            phase_in = M_IDLE;
         end
      endcase
   end

   assign mdu_rsp.done     = done_ff;
   assign mdu_rsp.quotient = acc_ff;

endmodule

### rtl/core/piecewise_linear_table_interp_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core: breakpoint table with linear lookup
// Clears, appends to or queries a table of signed Q16.16 (time, value)
// breakpoints; queries search the table and interpolate or extrapolate.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+--------------------------------------
//   req_    | in  | req_tvalid/tready    | op, point_time, point_value, query_time
//   rsp_    | out | rsp_tvalid/tready    | interp_value, table_was_empty, saturated
//
// Clear and append complete as the request is taken; a query on an empty
// table goes straight to the final state. A query that extrapolates past
// either end reads the two entries at that end; a search inside the table
// is a binary search of table reads through the single RAM read port, then
// 33 multiply and 65 divide steps in the shared multiply/divide unit.
// Reset is synchronous and clears the entry count; table contents are not
// cleared. A stalled response holds the sequencer in its final state; a new
// request transfer is taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [1:0] op, [33:2] point_time, [65:34] point_value, [97:66] query_time
   input  logic [pwl_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [31:0] interp_value, [32] table_was_empty, [33] saturated
   output logic [pwl_pkg::RSP_W-1:0] rsp_tdata
);
   import pwl_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = CNT_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   // sequencer and table bookkeeping
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // query operands and search bounds
   logic signed [31:0]       q_ff, q_in;
   logic signed [31:0]       x0_ff, x0_in, y0_ff, y0_in;
   logic signed [31:0]       x1_ff, x1_in, y1_ff, y1_in;
   logic signed [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [ADDR_W-1:0]        i1_ff, i1_in;
   logic                     neg_ff, neg_in;

   // result staging and output register
   logic signed [31:0]       res_value_ff, res_value_in;
   logic                     res_empty_ff, res_empty_in;
   logic                     res_sat_ff, res_sat_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   // request fields
   op_type                   req_op;
   logic signed [31:0]       req_point_time, req_point_value, req_query_time;
   logic                     req_xfer;

   // table RAM
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [63:0]              ram_rd_data;
   logic signed [31:0]       rd_time, rd_value;

   // search helpers
   logic [ADDR_W-1:0]        last_addr, prev_addr;
   logic signed [IDX_W-1:0]  last_idx;
   logic signed [IDX_W:0]    bound_sum;
   logic signed [IDX_W-1:0]  mid_idx;
   logic [ADDR_W-1:0]        i0_addr, i1_addr;

   // line evaluation
   logic signed [32:0]       dq, dy, span_raw, span;
   mdu_req_type              mdu_req;
   mdu_rsp_type              mdu_rsp;
   logic [PROD_W-1:0]        quo;
   logic signed [35:0]       quo_signed, line_sum;

   function automatic logic [MAG_W-1:0] mag33(input logic signed [32:0] v);
      mag33 = v[32] ? (~v + 33'd1) : v;
   endfunction

   assign req_op          = op_type'(req_tdata[OP_LSB +: 2]);
   assign req_point_time  = req_tdata[POINT_TIME_LSB +: 32];
   assign req_point_value = req_tdata[POINT_VALUE_LSB +: 32];
   assign req_query_time  = req_tdata[QUERY_TIME_LSB +: 32];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign rd_time  = ram_rd_data[31:0];
   assign rd_value = ram_rd_data[63:32];

   // entries are stored as {value, time}; appends land at the current count
   pwl_ram #(
      .WIDTH (64),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_point_value, req_point_time}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pwl_mdu u_mdu (
      .clock   (clock),
      .reset   (reset),
      .mdu_req (mdu_req),
      .mdu_rsp (mdu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      i1_ff        <= i1_in;
      neg_ff       <= neg_in;
      res_value_ff <= res_value_in;
      res_empty_ff <= res_empty_in;
      res_sat_ff   <= res_sat_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // search arithmetic; valid whenever the sequencer reads it
   always_comb begin
      last_addr = ADDR_W'(count_ff - CNT_W'(1));
      prev_addr = ADDR_W'(count_ff - CNT_W'(2));
      last_idx  = $signed({1'b0, count_ff}) - IDX_W'(1);
      bound_sum = {lo_ff[IDX_W-1], lo_ff} + {hi_ff[IDX_W-1], hi_ff};
      mid_idx   = bound_sum[IDX_W:1];
      // clamp the final bounds to the table ends
      i0_addr   = hi_ff[IDX_W-1] ? '0 : hi_ff[ADDR_W-1:0];
      i1_addr   = (lo_ff > last_idx) ? last_addr : lo_ff[ADDR_W-1:0];
   end

   // line operands: dq = q - x0, dy = y1 - y0, span = x1 - x0 (1.0 when flat)
   always_comb begin
      dq       = {q_ff[31], q_ff} - {x0_ff[31], x0_ff};
      dy       = {y1_ff[31], y1_ff} - {y0_ff[31], y0_ff};
      span_raw = {x1_ff[31], x1_ff} - {x0_ff[31], x0_ff};
      span     = (span_raw == '0) ? SPAN_ONE : span_raw;
      quo        = mdu_rsp.quotient;
      quo_signed = neg_ff ? -$signed(quo[35:0]) : $signed(quo[35:0]);
      line_sum   = {{4{y0_ff[31]}}, y0_ff} + quo_signed;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      q_in         = q_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      i1_in        = i1_ff;
      neg_in       = neg_ff;
      res_value_in = res_value_ff;
      res_empty_in = res_empty_ff;
      res_sat_in   = res_sat_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_rd_addr  = '0;
      mdu_req      = '{mag_a: mag33(dq), mag_b: mag33(dy), mag_d: mag33(span),
                       start: 1'b0};

      // drop the response once the consumer takes it
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            res_empty_in = 1'b0;
            res_sat_in   = 1'b0;
            q_in         = req_query_time;
            if (req_xfer) begin
               unique case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     // ignore appends once the table is full
                     if (count_ff != FULL_COUNT) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        res_value_in = '0;
                        res_empty_in = 1'b1;
                        state_in     = S_DONE;
                     end else begin
                        ram_rd_addr = '0;
                        state_in    = S_FIRST;
                     end
                  end
                  default: begin
                     // unused op code: no effect, no response
                  end
               endcase
            end
         end

         S_FIRST: begin
            x0_in = rd_time;
            y0_in = rd_value;
            if (count_ff == CNT_W'(1)) begin
               // single entry: return its value
               res_value_in = rd_value;
               state_in     = S_DONE;
            end else if (q_ff <= rd_time) begin
               ram_rd_addr = ADDR_W'(1);
               state_in    = S_EXT_LO;
            end else begin
               ram_rd_addr = last_addr;
               state_in    = S_LAST;
            end
         end

         S_EXT_LO: begin
            x1_in    = rd_time;
            y1_in    = rd_value;
            state_in = S_CALC;
         end

         S_LAST: begin
            if (q_ff >= rd_time) begin
               // extrapolate past the top from the last two entries
               x1_in       = rd_time;
               y1_in       = rd_value;
               ram_rd_addr = prev_addr;
               state_in    = S_EXT_HI;
            end else begin
               lo_in    = '0;
               hi_in    = last_idx;
               state_in = S_SEARCH;
            end
         end

         S_EXT_HI: begin
            x0_in    = rd_time;
            y0_in    = rd_value;
            state_in = S_CALC;
         end

         S_SEARCH: begin
            if (lo_ff <= hi_ff) begin
               ram_rd_addr = mid_idx[ADDR_W-1:0];
               mid_in      = mid_idx;
               state_in    = S_PROBE;
            end else begin
               ram_rd_addr = i0_addr;
               i1_in       = i1_addr;
               state_in    = S_PAIR0;
            end
         end

         S_PROBE: begin
            priority if (rd_time == q_ff) begin
               // exact hit on a breakpoint time
               res_value_in = rd_value;
               state_in     = S_DONE;
            end else if (rd_time < q_ff) begin
               lo_in    = mid_ff + IDX_W'(1);
               state_in = S_SEARCH;
            end else begin
               hi_in    = mid_ff - IDX_W'(1);
               state_in = S_SEARCH;
            end
         end

         S_PAIR0: begin
            x0_in = rd_time;
            y0_in = rd_value;
            if (i0_addr == i1_ff) begin
               // both bounds clamp to one entry
               res_value_in = rd_value;
               state_in     = S_DONE;
            end else begin
               ram_rd_addr = i1_ff;
               state_in    = S_PAIR1;
            end
         end

         S_PAIR1: begin
            x1_in    = rd_time;
            y1_in    = rd_value;
            state_in = S_CALC;
         end

         S_CALC: begin
            neg_in        = dq[32] ^ dy[32] ^ span[32];
            mdu_req.start = 1'b1;
            state_in      = S_WAIT;
         end

         S_WAIT: begin
            if (mdu_rsp.done) begin
               priority if (quo > SAT_LIMIT) begin
                  res_value_in = neg_ff ? Q_MIN : Q_MAX;
                  res_sat_in   = 1'b1;
               end else if (line_sum > SUM_MAX) begin
                  res_value_in = Q_MAX;
                  res_sat_in   = 1'b1;
               end else if (line_sum < SUM_MIN) begin
                  res_value_in = Q_MIN;
                  res_sat_in   = 1'b1;
               end else begin
                  res_value_in = line_sum[31:0];
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[INTERP_VALUE_LSB +: 32] = res_value_ff;
               rsp_data_in[TABLE_EMPTY_BIT]        = res_empty_ff;
               rsp_data_in[SATURATED_BIT]          = res_sat_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   // an accepted append into a non-full table grows it by exactly one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_op == OP_APPEND && count_ff != FULL_COUNT)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance entry count");

   // the divider finishes only while the sequencer waits for it
   a_mdu_done_wait: assert property (@(posedge clock) disable iff (reset)
      mdu_rsp.done |-> state_ff == S_WAIT)
      else $error("divide result arrived outside wait state");

   // a probe always reads an entry inside the table
   a_probe_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && lo_ff <= hi_ff)
      |-> (!mid_idx[IDX_W-1] && mid_idx < $signed({1'b0, count_ff})))
      else $error("search probe outside table");

   // a new response comes only out of the final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && $past(!rsp_valid_ff || rsp_tready) && !$past(reset))
      |-> $past(state_ff == S_DONE))
      else $error("response loaded outside final state");

endmodule
